### hw/rtl/mnba_pkg.sv
// Shared types and constants for the major number bitmap allocator.
// No dependencies; used by mnba_find_free and the top level.
package mnba_pkg;

	localparam int NUM_NUMBERS = 128;
	localparam int IDX_W       = $clog2(NUM_NUMBERS);
	localparam int GRP_W       = 8;
	localparam int GRP_BITS    = $clog2(GRP_W);
	localparam int NUM_GRPS    = (NUM_NUMBERS + GRP_W - 1) / GRP_W;
	localparam int GRP_IDX_W   = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;
	localparam int CNT_W       = 8;

	localparam logic [7:0] MAJ_BASE = 8'd128;
	localparam logic [CNT_W-1:0] NUM_FS_TYPES_RST = CNT_W'(4);
	localparam logic [CNT_W-1:0] MAP_LIMIT = CNT_W'(NUM_NUMBERS);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_POOL     = 2'd0,
		ST_FALLBACK = 2'd1,
		ST_FREED    = 2'd2,
		ST_IGNORED  = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t       command;
		logic [6:0] fs_type;
		logic [7:0] number;
	} req_t;

	typedef struct packed {
		logic [7:0] major_number;
		status_t    status;
	} rsp_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} find_t;

endpackage

### hw/rtl/major_number_bitmap_allocator_unit.sv
// Major number bitmap allocator: top level.
// Depends on mnba_pkg and mnba_find_free.
// The accepting edge loads req_s1; done and result are then registered from it.
// Throughput: one item per cycle; busy is always low.
// The used map is a flop register updated in the compute stage, so the next item sees it.
// Reset clears the map and sets num_fs_types to 4; results cannot be stalled.
module major_number_bitmap_allocator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  mnba_pkg::req_t                 request,
	output logic                           done,
	output mnba_pkg::rsp_t                 result,
	input  logic                           cfg_we,
	input  logic [mnba_pkg::CNT_W-1:0]     cfg_wdata
);

	logic                              valid_s1;
	mnba_pkg::req_t                    req_s1;
	logic [mnba_pkg::CNT_W-1:0]        num_fs_types_q;
	logic [mnba_pkg::NUM_NUMBERS-1:0]  used_q;
	logic                              done_q;
	mnba_pkg::rsp_t                    result_q;

	logic [mnba_pkg::CNT_W-1:0]        nres;
	logic [mnba_pkg::NUM_NUMBERS-1:0]  res_mask;
	logic [mnba_pkg::NUM_NUMBERS-1:0]  map_res;
	logic [mnba_pkg::NUM_NUMBERS-1:0]  used_d;
	mnba_pkg::find_t                   hit;
	mnba_pkg::rsp_t                    rsp_d;
	logic [7:0]                        free_idx;
	logic                              free_ok;

	assign busy = 1'b0;

	always_comb begin
		nres = (num_fs_types_q > mnba_pkg::MAP_LIMIT) ? mnba_pkg::MAP_LIMIT : num_fs_types_q;
		for (int i = 0; i < mnba_pkg::NUM_NUMBERS; i++) begin
			res_mask[i] = (mnba_pkg::CNT_W'(i) < nres);
		end
		map_res = used_q | res_mask;
	end

	mnba_find_free u_find (
		.used (map_res),
		.hit  (hit)
	);

	always_comb begin
		free_idx = req_s1.number - mnba_pkg::MAJ_BASE;
		free_ok  = req_s1.number[7]
			&& (free_idx < mnba_pkg::MAP_LIMIT)
			&& (free_idx != {1'b0, req_s1.fs_type});
		used_d = used_q;
		rsp_d.major_number = mnba_pkg::MAJ_BASE;
		rsp_d.status       = mnba_pkg::ST_IGNORED;
		unique case (req_s1.command)
			mnba_pkg::CMD_ALLOC: begin
				used_d = map_res;
				if (hit.found) begin
					used_d[hit.idx]    = 1'b1;
					rsp_d.major_number = mnba_pkg::MAJ_BASE + 8'(hit.idx);
					rsp_d.status       = mnba_pkg::ST_POOL;
				end else begin
					rsp_d.major_number = mnba_pkg::MAJ_BASE + {1'b0, req_s1.fs_type};
					rsp_d.status       = mnba_pkg::ST_FALLBACK;
				end
			end
			mnba_pkg::CMD_FREE: begin
				if (free_ok) begin
					used_d[free_idx[mnba_pkg::IDX_W-1:0]] = 1'b0;
					rsp_d.status = mnba_pkg::ST_FREED;
				end
			end
			default: begin
				used_d = used_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			done_q         <= 1'b0;
			num_fs_types_q <= mnba_pkg::NUM_FS_TYPES_RST;
			used_q         <= '0;
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1;
			if (cfg_we) begin
				num_fs_types_q <= cfg_wdata;
			end
			if (valid_s1) begin
				used_q <= used_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
		if (valid_s1) begin
			result_q <= rsp_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### hw/rtl/mnba_find_free.sv
// Lowest-clear-bit finder over the used map: two-level priority encoder.
// Depends on mnba_pkg.
module mnba_find_free (
	input  logic [mnba_pkg::NUM_NUMBERS-1:0] used,
	output mnba_pkg::find_t                  hit
);

	localparam int PAD_W = mnba_pkg::NUM_GRPS * mnba_pkg::GRP_W;

	logic [PAD_W-1:0]                                     padded;
	logic [mnba_pkg::NUM_GRPS-1:0]                        grp_free;
	logic [mnba_pkg::NUM_GRPS-1:0][mnba_pkg::GRP_BITS-1:0] grp_idx;
	logic [mnba_pkg::GRP_IDX_W-1:0]                       sel_grp;
	logic [mnba_pkg::GRP_IDX_W+mnba_pkg::GRP_BITS-1:0]    full_idx;

	always_comb begin
		padded = '1;
		padded[mnba_pkg::NUM_NUMBERS-1:0] = used;
		for (int g = 0; g < mnba_pkg::NUM_GRPS; g++) begin
			grp_free[g] = ~&padded[g*mnba_pkg::GRP_W +: mnba_pkg::GRP_W];
			grp_idx[g]  = '0;
			for (int b = mnba_pkg::GRP_W - 1; b >= 0; b--) begin
				if (!padded[g*mnba_pkg::GRP_W + b]) begin
					grp_idx[g] = mnba_pkg::GRP_BITS'(b);
				end
			end
		end
	end

	always_comb begin
		sel_grp = '0;
		for (int g = mnba_pkg::NUM_GRPS - 1; g >= 0; g--) begin
			if (grp_free[g]) begin
				sel_grp = mnba_pkg::GRP_IDX_W'(g);
			end
		end
		full_idx = {sel_grp, grp_idx[sel_grp]};
		hit.found = |grp_free;
		hit.idx   = full_idx[mnba_pkg::IDX_W-1:0];
	end

endmodule

### tb/sv/mnba_grant_checker.sv
// Checker for the major number bitmap allocator: watches the request,
// result and register channels, predicts each grant and compares.
// Depends on mnba_pkg.
module mnba_grant_checker
	import mnba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  req_t             request,
	input  logic             done,
	input  rsp_t             result,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output int               errors,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [NUM_NUMBERS-1:0] used_bits;
	logic [CNT_W-1:0]       reserved_cnt;
	rsp_t                   pending_grants[$];
	int                     mismatch_cnt;

	function automatic rsp_t predict_grant(input req_t r);
		rsp_t        o;
		int unsigned nres;
		int unsigned idx;
		int          slot;
		o.major_number = MAJ_BASE;
		o.status       = ST_IGNORED;
		if (r.command == CMD_ALLOC) begin
			nres = (reserved_cnt > NUM_NUMBERS) ? NUM_NUMBERS : reserved_cnt;
			for (int i = 0; i < nres; i++)
				used_bits[i] = 1'b1;
			slot = -1;
			for (int i = 0; i < NUM_NUMBERS; i++) begin
				if (slot < 0 && !used_bits[i])
					slot = i;
			end
			if (slot >= 0) begin
				used_bits[slot] = 1'b1;
				o.major_number  = MAJ_BASE + 8'(slot);
				o.status        = ST_POOL;
			end else begin
				o.major_number = MAJ_BASE + 8'(r.fs_type);
				o.status       = ST_FALLBACK;
			end
		end else if (r.number >= MAJ_BASE) begin
			idx = r.number - MAJ_BASE;
			if (idx < NUM_NUMBERS && idx != r.fs_type) begin
				used_bits[idx] = 1'b0;
				o.status       = ST_FREED;
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			used_bits    = '0;
			reserved_cnt = NUM_FS_TYPES_RST;
			pending_grants.delete();
			mismatch_cnt = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				reserved_cnt = cfg_wdata;
			if (done) begin
				if (pending_grants.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: unexpected result major=%0d status=%0d",
							$time, result.major_number, result.status);
				end else begin
					want = pending_grants.pop_front();
					if (result.major_number !== want.major_number ||
						result.status !== want.status) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("%0t: mismatch exp major=%0d status=%0d, got major=%0d status=%0d",
								$time, want.major_number, want.status,
								result.major_number, result.status);
					end
				end
			end
			if (start && !busy)
				pending_grants.push_back(predict_grant(request));
			outstanding <= pending_grants.size();
			errors      <= mismatch_cnt;
		end
	end

endmodule

### tb/sv/tb_top.sv
// Top of the allocator testbench: clock, reset, directed and random
// request stimulus, register writes between phases, watchdog and verdict.
// Depends on mnba_pkg, mnba_grant_checker and major_number_bitmap_allocator_unit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mnba_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 108;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             request;
	logic             done;
	rsp_t             result;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	int               errors;
	int               outstanding;
	int               stall_cnt = 0;

	major_number_bitmap_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	mnba_grant_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic issue(input cmd_t c, input logic [6:0] fs, input logic [7:0] num,
		input int gap_pct);
		req_t r;
		r.command = c;
		r.fs_type = fs;
		r.number  = num;
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_reserved(input logic [CNT_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CNT_W-1:0] phase_cfg [12];
		logic [6:0]       fs;
		logic [7:0]       num;
		int               idle_pct;
		int               alloc_pct;
		int               pick;
		phase_cfg = '{8'd4, 8'd0, 8'd255, 8'd1, 8'd128, 8'd2,
			8'd0, 8'd127, 8'd3, 8'd8, 8'd129, 8'd5};
		arst_n    <= 1'b0;
		start     <= 1'b0;
		request   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: four reserved numbers
		issue(CMD_ALLOC, 7'd0,   8'd0,   0);
		issue(CMD_ALLOC, 7'd127, 8'd255, 0);
		issue(CMD_FREE,  7'd5,   8'd0,   0);
		issue(CMD_FREE,  7'd5,   8'd127, 0);
		issue(CMD_FREE,  7'd3,   8'd131, 0);
		issue(CMD_FREE,  7'd0,   8'd129, 0);
		issue(CMD_ALLOC, 7'd9,   8'd0,   0);
		issue(CMD_FREE,  7'd2,   8'd200, 0);
		issue(CMD_FREE,  7'd127, 8'd255, 0);
		issue(CMD_FREE,  7'd0,   8'd255, 0);
		issue(CMD_FREE,  7'd7,   8'd132, 0);
		issue(CMD_ALLOC, 7'd1,   8'd0,   0);

		set_reserved(8'd128);
		issue(CMD_ALLOC, 7'd127, 8'd0,   0);
		issue(CMD_ALLOC, 7'd0,   8'd0,   0);
		issue(CMD_FREE,  7'd1,   8'd150, 0);
		issue(CMD_ALLOC, 7'd40,  8'd0,   0);

		set_reserved(8'd255);
		issue(CMD_ALLOC, 7'd64,  8'd0,   0);

		set_reserved(8'd0);
		issue(CMD_ALLOC, 7'd2,   8'd0,   0);
		issue(CMD_FREE,  7'd1,   8'd128, 0);
		issue(CMD_ALLOC, 7'd2,   8'd0,   0);
		issue(CMD_ALLOC, 7'd2,   8'd0,   0);

		for (int ph = 0; ph < 12; ph++) begin
			idle_pct  = (ph < 4) ? 25 : (ph < 8) ? 55 : 0;
			alloc_pct = ph[0] ? 35 : 75;
			set_reserved(phase_cfg[ph]);
			repeat (PHASE_ITEMS) begin
				fs = 7'($urandom_range(0, 127));
				if ($urandom_range(99) < alloc_pct) begin
					issue(CMD_ALLOC, fs, 8'($urandom), idle_pct);
				end else begin
					pick = $urandom_range(9);
					if (pick == 0)
						num = 8'($urandom_range(0, 127));
					else if (pick == 1)
						num = MAJ_BASE + 8'(fs);
					else
						num = 8'($urandom_range(128, 255));
					issue(CMD_FREE, fs, num, idle_pct);
				end
			end
		end

		wait_idle();
		repeat (4)
			@(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
